// ===== design/bhcs_pkg.sv =====
`timescale 1ns / 1ps

package bhcs_pkg;

   // Speed filter geometry.
   localparam int HISTORY_DEPTH = 8;
   localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
   localparam int SAMPLE_W      = 15;
   localparam int SUM_W         = SAMPLE_W + SLOT_W;

   // Largest speed sample; larger quotients are clamped to it.
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 15'h7FFF;

   // Divider geometry: 24-bit dividend, 32-bit tick count.
   localparam int DVD_W  = 24;
   localparam int DVS_W  = 32;
   localparam int STEP_W = $clog2(DVD_W);

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_CONSTANT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCARD_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTAGE_LIMIT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_GAIN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_LIMIT     = 3'd4;

   localparam logic [23:0] RST_SPEED_CONSTANT    = 24'd638624;
   localparam logic [14:0] RST_DISCARD_THRESHOLD = 15'd2000;
   localparam logic [23:0] RST_VOLTAGE_LIMIT     = 24'd58080;
   localparam logic [7:0]  RST_BATTERY_GAIN      = 8'd63;
   localparam logic [14:0] RST_COMMAND_LIMIT     = 15'd1000;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                push;
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] threshold;
   } flt_req_type;

endpackage

// ===== design/bhcs_divider.sv =====
`timescale 1ns / 1ps

module bhcs_divider import bhcs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVD_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   logic [DVD_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   // The remainder never exceeds a prefix of the dividend, so it stays 24 bits wide.
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign fits  = {{(DVS_W-DVD_W){1'b0}}, trial} >= {1'b0, dvs_ff};
   assign diff  = {{(DVS_W-DVD_W){1'b0}}, trial} - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVD_W-1:0] : trial[DVD_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], fits};
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

// ===== design/bhcs_speed_filter.sv =====
`timescale 1ns / 1ps

module bhcs_speed_filter import bhcs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  flt_req_type         flt_req,
   output logic [SAMPLE_W-1:0] filtered
);

   logic [SAMPLE_W-1:0] hist_ff [HISTORY_DEPTH];
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [SAMPLE_W-1:0] filt_ff, filt_in;

   logic [SAMPLE_W-1:0] avg;
   logic [SAMPLE_W-1:0] dev;
   logic [SAMPLE_W-1:0] kept;

   assign avg  = SAMPLE_W'(sum_ff / SUM_W'(HISTORY_DEPTH));
   assign dev  = (avg > flt_req.sample) ? avg - flt_req.sample : flt_req.sample - avg;
   // An outlier is replaced by the current average rather than dropped.
   assign kept = (dev > flt_req.threshold) ? avg : flt_req.sample;

   always_comb begin
      sum_in  = sum_ff;
      slot_in = slot_ff;
      filt_in = filt_ff;
      if (flt_req.push) begin
         sum_in  = sum_ff - SUM_W'(hist_ff[slot_ff]) + SUM_W'(kept);
         slot_in = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
         filt_in = SAMPLE_W'(sum_in / SUM_W'(HISTORY_DEPTH));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         slot_ff <= '0;
         filt_ff <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         sum_ff  <= sum_in;
         slot_ff <= slot_in;
         filt_ff <= filt_in;
         if (flt_req.push) begin
            hist_ff[slot_ff] <= kept;
         end
      end
   end

   assign filtered = filt_ff;

endmodule

// ===== design/bldc_hall_commutation_speed_unit.sv =====
`timescale 1ns / 1ps

// Six-step hall commutation with speed measurement and a checked drive command.
// Request channel: req_valid/req_stall carry one beat per timer tick (kind 0,
// hall code) or drive command (kind 1, signed command value). Response channel:
// rsp_valid/rsp_stall return exactly one beat per request with the phase duties,
// low-side enables, filtered velocity and active command.
// One request is worked on at a time; req_stall is high from the accepting edge
// until the response has been loaded into the output register.
// A tick whose hall code is unchanged goes straight to the output stage; a tick
// with a hall change first runs the 24-bit restoring divider, one quotient bit
// per cycle, and pushes the speed sample into the filter; a command passes a
// multiply state and a check state before the output stage.
// A new request may be accepted while the previous response is still waiting.
// If the receiver stalls, the response register holds its beat and the finished
// next result waits in the sequencer until the register frees up.
// Synchronous reset restores all configuration registers to their defaults,
// clears the speed history and returns the sequencer to idle with no beat out.
// Configuration writes take effect at the next edge and are meant for idle times.

module bldc_hall_commutation_speed_unit import bhcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [2:0]            req_hall_code,
   input  logic signed [15:0]    req_command_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [14:0]           rsp_phase1_duty,
   output logic [14:0]           rsp_phase2_duty,
   output logic [14:0]           rsp_phase3_duty,
   output logic                  rsp_phase1_enable,
   output logic                  rsp_phase2_enable,
   output logic                  rsp_phase3_enable,
   output logic signed [15:0]    rsp_velocity,
   output logic signed [15:0]    rsp_active_command,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DIVIDE  = 3'd1;
   localparam logic [2:0] ST_CMD_MUL = 3'd2;
   localparam logic [2:0] ST_CMD_CHK = 3'd3;
   localparam logic [2:0] ST_FINISH  = 3'd4;

   localparam logic [2:0] HALL_110 = 3'b110;
   localparam logic [2:0] HALL_010 = 3'b010;
   localparam logic [2:0] HALL_011 = 3'b011;
   localparam logic [2:0] HALL_001 = 3'b001;
   localparam logic [2:0] HALL_101 = 3'b101;
   localparam logic [2:0] HALL_100 = 3'b100;
   localparam logic [2:0] HALL_NONE = 3'b000;

   localparam logic        KIND_TICK = 1'b0;

   // Hall code that follows each code in forward rotation; none for invalid codes.
   function automatic logic [2:0] next_forward(input logic [2:0] h);
      logic [2:0] r;
      unique case (h)
         HALL_110: r = HALL_010;
         HALL_010: r = HALL_011;
         HALL_011: r = HALL_001;
         HALL_001: r = HALL_101;
         HALL_101: r = HALL_100;
         HALL_100: r = HALL_110;
         default:  r = HALL_NONE;
      endcase
      return r;
   endfunction

   // Returns {floated phase one-hot, zero-duty phase one-hot in forward drive}, bit 0 is phase one.
   function automatic logic [5:0] commutation(input logic [2:0] h);
      logic [5:0] r;
      unique case (h)
         HALL_110: r = {3'b001, 3'b100};
         HALL_010: r = {3'b100, 3'b001};
         HALL_011: r = {3'b010, 3'b001};
         HALL_001: r = {3'b001, 3'b010};
         HALL_101: r = {3'b100, 3'b010};
         HALL_100: r = {3'b010, 3'b100};
         default:  r = 6'b000000;
      endcase
      return r;
   endfunction

   // Configuration registers.
   logic [23:0] spd_const_ff;
   logic [14:0] discard_ff;
   logic [23:0] volt_lim_ff;
   logic [7:0]  gain_ff;
   logic [14:0] cmd_lim_ff;

   // Block state.
   logic [2:0]         state_ff, state_in;
   logic [2:0]         prev_hall_ff, prev_hall_in;
   logic [31:0]        tick_cnt_ff, tick_cnt_in;
   logic signed [2:0]  vote_ff, vote_in;
   logic               meas_fwd_ff, meas_fwd_in;
   logic [14:0]        duty_lvl_ff, duty_lvl_in;
   logic               drive_fwd_ff, drive_fwd_in;
   logic signed [15:0] acc_cmd_ff, acc_cmd_in;

   // Command working registers.
   logic signed [15:0] cmd_ff, cmd_in;
   logic [22:0]        prod_ff, prod_in;
   logic               agree_ff, agree_in;
   logic               in_range_ff, in_range_in;

   // Pending result and response register.
   logic [14:0] res_duty_ff [3];
   logic [14:0] res_duty_in [3];
   logic [2:0]  res_en_ff, res_en_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [14:0]        rsp_duty_ff [3];
   logic [2:0]         rsp_en_ff;
   logic signed [15:0] rsp_vel_ff;
   logic signed [15:0] rsp_acc_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;
   flt_req_type flt_req;
   logic [SAMPLE_W-1:0] filtered;

   logic               accept;
   logic               load_rsp;
   logic [5:0]         comm;
   logic [2:0]         succ;
   logic signed [3:0]  vote_sum;
   logic signed [16:0] cmd_wide;
   logic signed [16:0] lim_wide;
   logic [15:0]        cmd_mag;
   logic [18:0]        emf;
   logic signed [24:0] coil_v;
   logic [15:0]        acc_mag;
   logic signed [15:0] vel_now;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign load_rsp = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign comm     = commutation(req_hall_code);
   assign succ     = next_forward(prev_hall_ff);

   assign cmd_wide = {cmd_ff[15], cmd_ff};
   assign lim_wide = {2'b00, cmd_lim_ff};
   assign cmd_mag  = cmd_ff[15] ? 16'(-cmd_ff) : 16'(cmd_ff);
   assign emf      = 19'(filtered) * 19'd10;
   assign coil_v   = agree_ff ? $signed({2'b00, prod_ff}) - $signed({6'b000000, emf})
                              : $signed({2'b00, prod_ff}) + $signed({6'b000000, emf});
   assign vel_now  = meas_fwd_ff ? $signed({1'b0, filtered}) : -$signed({1'b0, filtered});

   always_comb begin
      vote_sum = {vote_ff[2], vote_ff};
      if (succ != HALL_NONE) begin
         vote_sum = (req_hall_code == succ) ? vote_sum + 4'sd1 : vote_sum - 4'sd1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      prev_hall_in = prev_hall_ff;
      tick_cnt_in  = tick_cnt_ff;
      vote_in      = vote_ff;
      meas_fwd_in  = meas_fwd_ff;
      duty_lvl_in  = duty_lvl_ff;
      drive_fwd_in = drive_fwd_ff;
      acc_cmd_in   = acc_cmd_ff;
      cmd_in       = cmd_ff;
      prod_in      = prod_ff;
      agree_in     = agree_ff;
      in_range_in  = in_range_ff;
      res_duty_in  = res_duty_ff;
      res_en_in    = res_en_ff;
      acc_mag      = '0;

      div_req.start    = 1'b0;
      div_req.dividend = spd_const_ff;
      div_req.divisor  = tick_cnt_ff;

      flt_req.push      = 1'b0;
      flt_req.sample    = (div_rsp.quotient > DVD_W'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                                 : div_rsp.quotient[14:0];
      flt_req.threshold = discard_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_TICK) begin
                  // Duties use the drive state from before this tick.
                  for (int k = 0; k < 3; k++) begin
                     res_en_in[k] = !comm[3 + k];
                     if (comm[2:0] != 3'b000 && ((!comm[k]) == drive_fwd_ff)) begin
                        res_duty_in[k] = duty_lvl_ff;
                     end else begin
                        res_duty_in[k] = '0;
                     end
                  end
                  if (req_hall_code == prev_hall_ff) begin
                     if (tick_cnt_ff != '1) begin
                        tick_cnt_in = tick_cnt_ff + 1'b1;
                     end
                     state_in = ST_FINISH;
                  end else begin
                     if (vote_sum > 4'sd3) begin
                        vote_in     = 3'sd3;
                        meas_fwd_in = 1'b1;
                     end else if (vote_sum < -4'sd3) begin
                        vote_in     = -3'sd3;
                        meas_fwd_in = 1'b0;
                     end else begin
                        vote_in = vote_sum[2:0];
                     end
                     div_req.start = 1'b1;
                     tick_cnt_in   = 32'd1;
                     prev_hall_in  = req_hall_code;
                     state_in      = ST_DIVIDE;
                  end
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     res_duty_in[k] = '0;
                  end
                  res_en_in = '0;
                  cmd_in    = req_command_value;
                  state_in  = ST_CMD_MUL;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               flt_req.push = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_CMD_MUL: begin
            in_range_in = (cmd_wide <= lim_wide) && (cmd_wide >= -lim_wide);
            prod_in     = 23'(gain_ff) * 23'(cmd_mag[14:0]);
            agree_in    = meas_fwd_ff ? !cmd_ff[15] : cmd_ff[15];
            state_in    = ST_CMD_CHK;
         end
         ST_CMD_CHK: begin
            if (in_range_ff) begin
               if (coil_v <= $signed({1'b0, volt_lim_ff})) begin
                  acc_cmd_in = cmd_ff;
               end
               acc_mag      = acc_cmd_in[15] ? 16'(-acc_cmd_in) : 16'(acc_cmd_in);
               duty_lvl_in  = acc_mag[15] ? 15'h7FFF : acc_mag[14:0];
               drive_fwd_in = !acc_cmd_in[15];
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spd_const_ff <= RST_SPEED_CONSTANT;
         discard_ff   <= RST_DISCARD_THRESHOLD;
         volt_lim_ff  <= RST_VOLTAGE_LIMIT;
         gain_ff      <= RST_BATTERY_GAIN;
         cmd_lim_ff   <= RST_COMMAND_LIMIT;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SPEED_CONSTANT:    spd_const_ff <= csr_data;
            CSR_DISCARD_THRESHOLD: discard_ff   <= csr_data[14:0];
            CSR_VOLTAGE_LIMIT:     volt_lim_ff  <= csr_data;
            CSR_BATTERY_GAIN:      gain_ff      <= csr_data[7:0];
            CSR_COMMAND_LIMIT:     cmd_lim_ff   <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_hall_ff <= HALL_NONE;
         tick_cnt_ff  <= 32'd1;
         vote_ff      <= '0;
         meas_fwd_ff  <= 1'b1;
         duty_lvl_ff  <= '0;
         drive_fwd_ff <= 1'b1;
         acc_cmd_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_hall_ff <= prev_hall_in;
         tick_cnt_ff  <= tick_cnt_in;
         vote_ff      <= vote_in;
         meas_fwd_ff  <= meas_fwd_in;
         duty_lvl_ff  <= duty_lvl_in;
         drive_fwd_ff <= drive_fwd_in;
         acc_cmd_ff   <= acc_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      prod_ff     <= prod_in;
      agree_ff    <= agree_in;
      in_range_ff <= in_range_in;
      res_duty_ff <= res_duty_in;
      res_en_ff   <= res_en_in;
      if (load_rsp) begin
         rsp_duty_ff <= res_duty_ff;
         rsp_en_ff   <= res_en_ff;
         rsp_vel_ff  <= vel_now;
         rsp_acc_ff  <= acc_cmd_ff;
      end
   end

   bhcs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   bhcs_speed_filter u_filter (
      .clock    (clock),
      .reset    (reset),
      .flt_req  (flt_req),
      .filtered (filtered)
   );

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_phase1_duty    = rsp_duty_ff[0];
   assign rsp_phase2_duty    = rsp_duty_ff[1];
   assign rsp_phase3_duty    = rsp_duty_ff[2];
   assign rsp_phase1_enable  = rsp_en_ff[0];
   assign rsp_phase2_enable  = rsp_en_ff[1];
   assign rsp_phase3_enable  = rsp_en_ff[2];
   assign rsp_velocity       = rsp_vel_ff;
   assign rsp_active_command = rsp_acc_ff;

endmodule

// ===== design/bhcs_checker.sv =====
`timescale 1ns / 1ps

module bhcs_checker import bhcs_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [14:0]           rsp_phase1_duty,
   input logic [14:0]           rsp_phase2_duty,
   input logic [14:0]           rsp_phase3_duty,
   input logic                  rsp_phase1_enable,
   input logic                  rsp_phase2_enable,
   input logic                  rsp_phase3_enable,
   input logic signed [15:0]    rsp_velocity,
   input logic signed [15:0]    rsp_active_command
);

   // A stalled response beat must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_velocity)
         && $stable(rsp_active_command) && $stable(rsp_phase1_duty))
      else $error("stalled response beat changed");

   // Only one request is in flight: the edge after an accepted beat the input stalls.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in progress");

   // A beat with every coil floated is a command result and carries no duty.
   a_cmd_no_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_phase1_enable && !rsp_phase2_enable && !rsp_phase3_enable
         |-> rsp_phase1_duty == 15'd0 && rsp_phase2_duty == 15'd0
            && rsp_phase3_duty == 15'd0)
      else $error("command result carries a phase duty");

   // The commutation never floats two coils at once.
   a_enable_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_phase1_enable, rsp_phase2_enable,
                                rsp_phase3_enable}) != 1)
      else $error("two phases floated in one beat");

endmodule

bind bldc_hall_commutation_speed_unit bhcs_checker u_bhcs_checker (.*);

// ===== bench/bhcs_drive_checker.sv =====
`timescale 1ns / 1ps

module bhcs_drive_checker import bhcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_kind,
   input  logic [2:0]            req_hall_code,
   input  logic signed [15:0]    req_command_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [14:0]           rsp_phase1_duty,
   input  logic [14:0]           rsp_phase2_duty,
   input  logic [14:0]           rsp_phase3_duty,
   input  logic                  rsp_phase1_enable,
   input  logic                  rsp_phase2_enable,
   input  logic                  rsp_phase3_enable,
   input  logic signed [15:0]    rsp_velocity,
   input  logic signed [15:0]    rsp_active_command,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    mismatch_count,
   output int                    pending_beats
);

   localparam logic KIND_TICK    = 1'b0;

   // Hall codes named after the sensors that read high (A, B, C = bits 2, 1, 0).
   localparam logic [2:0] HALL_NONE = 3'b000;
   localparam logic [2:0] HALL_C    = 3'b001;
   localparam logic [2:0] HALL_B    = 3'b010;
   localparam logic [2:0] HALL_BC   = 3'b011;
   localparam logic [2:0] HALL_A    = 3'b100;
   localparam logic [2:0] HALL_AC   = 3'b101;
   localparam logic [2:0] HALL_AB   = 3'b110;

   typedef struct packed {
      logic [14:0]        duty1;
      logic [14:0]        duty2;
      logic [14:0]        duty3;
      logic               en1;
      logic               en2;
      logic               en3;
      logic signed [15:0] velocity;
      logic signed [15:0] active_command;
   } drive_beat_type;

   drive_beat_type predicted_drive_q[$];

   // Configuration copy.
   logic [23:0] speed_k;
   logic [14:0] outlier_limit;
   logic [23:0] emf_limit;
   logic [7:0]  gain;
   logic [14:0] cmd_bound;

   // Commutation and speed state.
   logic [2:0]         hall_prev;
   logic [31:0]        dwell_ticks;
   int                 dir_score;
   bit                 turning_fwd;
   int unsigned        speed_ring [HISTORY_DEPTH];
   int unsigned        ring_sum;
   int unsigned        ring_ptr;
   int unsigned        mean_speed;
   logic [14:0]        drive_duty;
   bit                 drive_fwd;
   logic signed [15:0] cmd_held;

   initial begin
      mismatch_count = 0;
      pending_beats  = 0;
   end

   function automatic logic [2:0] hall_ahead(input logic [2:0] h);
      case (h)
         HALL_AB: return HALL_B;
         HALL_B:  return HALL_BC;
         HALL_BC: return HALL_C;
         HALL_C:  return HALL_AC;
         HALL_AC: return HALL_A;
         HALL_A:  return HALL_AB;
         default: return HALL_NONE;
      endcase
   endfunction

   task automatic clear_state();
      speed_k       = RST_SPEED_CONSTANT;
      outlier_limit = RST_DISCARD_THRESHOLD;
      emf_limit     = RST_VOLTAGE_LIMIT;
      gain          = RST_BATTERY_GAIN;
      cmd_bound     = RST_COMMAND_LIMIT;
      hall_prev     = HALL_NONE;
      dwell_ticks   = 1;
      dir_score     = 0;
      turning_fwd   = 1'b1;
      foreach (speed_ring[k]) speed_ring[k] = 0;
      ring_sum      = 0;
      ring_ptr      = 0;
      mean_speed    = 0;
      drive_duty    = '0;
      drive_fwd     = 1'b1;
      cmd_held      = '0;
   endtask

   task automatic predict_beat(input logic kind, input logic [2:0] hall,
                               input logic signed [15:0] cmd, output drive_beat_type beat);
      int              floated;
      int              grounded;
      int              c;
      int              lim;
      int              mag;
      int              vel;
      longint          emf;
      longint          volts;
      longint unsigned quot;
      int unsigned     sample;
      int unsigned     avg;
      int unsigned     dev;
      logic [2:0]      succ;
      logic [14:0]     duty_out [3];
      logic            en_out [3];
      bit              gets;
      bit              agree;
      beat = '0;
      if (kind == KIND_TICK) begin
         floated  = -1;
         grounded = -1;
         case (hall)
            HALL_AB: begin floated = 0; grounded = 2; end
            HALL_B:  begin floated = 2; grounded = 0; end
            HALL_BC: begin floated = 1; grounded = 0; end
            HALL_C:  begin floated = 0; grounded = 1; end
            HALL_AC: begin floated = 2; grounded = 1; end
            HALL_A:  begin floated = 1; grounded = 2; end
            default: ;
         endcase
         for (int k = 0; k < 3; k++) begin
            en_out[k]   = (k != floated);
            duty_out[k] = '0;
            if (grounded >= 0) begin
               gets = (k != grounded);
               // Reverse drive swaps which phases carry the duty.
               if (!drive_fwd) gets = !gets;
               duty_out[k] = gets ? drive_duty : '0;
            end
         end
         beat.duty1 = duty_out[0];
         beat.duty2 = duty_out[1];
         beat.duty3 = duty_out[2];
         beat.en1   = en_out[0];
         beat.en2   = en_out[1];
         beat.en3   = en_out[2];

         if (hall == hall_prev) begin
            if (dwell_ticks != '1) dwell_ticks++;
         end else begin
            succ = hall_ahead(hall_prev);
            if (succ != HALL_NONE) dir_score += (hall == succ) ? 1 : -1;
            if (dir_score > 3) begin
               dir_score   = 3;
               turning_fwd = 1'b1;
            end else if (dir_score < -3) begin
               dir_score   = -3;
               turning_fwd = 1'b0;
            end
            quot = (dwell_ticks == 0) ? 32767 : longint'(speed_k) / longint'(dwell_ticks);
            if (quot > 32767) quot = 32767;
            sample = quot;
            avg    = ring_sum / HISTORY_DEPTH;
            dev    = (avg > sample) ? avg - sample : sample - avg;
            if (dev > outlier_limit) sample = avg;
            ring_sum             = ring_sum - speed_ring[ring_ptr] + sample;
            speed_ring[ring_ptr] = sample;
            ring_ptr             = (ring_ptr + 1) % HISTORY_DEPTH;
            mean_speed           = ring_sum / HISTORY_DEPTH;
            dwell_ticks          = 1;
            hall_prev            = hall;
         end
      end else begin
         c   = cmd;
         lim = cmd_bound;
         if (c <= lim && c >= -lim) begin
            mag   = (c < 0) ? -c : c;
            emf   = longint'(mean_speed) * 10;
            agree = turning_fwd ? (c >= 0) : (c < 0);
            volts = longint'(gain) * mag + (agree ? -emf : emf);
            if (volts <= longint'(emf_limit)) cmd_held = cmd;
            mag        = (cmd_held < 0) ? -int'(cmd_held) : int'(cmd_held);
            drive_duty = (mag > 32767) ? 15'h7FFF : mag[14:0];
            drive_fwd  = (cmd_held >= 0);
         end
      end
      vel = turning_fwd ? int'(mean_speed) : -int'(mean_speed);
      beat.velocity       = vel[15:0];
      beat.active_command = cmd_held;
   endtask

   task automatic check_field(input string fname, input logic signed [31:0] want,
                              input logic signed [31:0] got, inout bit bad);
      if (got !== want) begin
         if (mismatch_count < 10)
            $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
         bad = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      drive_beat_type want;
      bit             bad;
      if (reset) begin
         clear_state();
         predicted_drive_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_SPEED_CONSTANT:    speed_k       = csr_data[23:0];
               CSR_DISCARD_THRESHOLD: outlier_limit = csr_data[14:0];
               CSR_VOLTAGE_LIMIT:     emf_limit     = csr_data[23:0];
               CSR_BATTERY_GAIN:      gain          = csr_data[7:0];
               CSR_COMMAND_LIMIT:     cmd_bound     = csr_data[14:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_beat(req_kind, req_hall_code, req_command_value, want);
            predicted_drive_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_drive_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: response beat with nothing expected", $time);
               mismatch_count++;
            end else begin
               want = predicted_drive_q.pop_front();
               bad  = 1'b0;
               check_field("phase1_duty", want.duty1, rsp_phase1_duty, bad);
               check_field("phase2_duty", want.duty2, rsp_phase2_duty, bad);
               check_field("phase3_duty", want.duty3, rsp_phase3_duty, bad);
               check_field("phase1_enable", want.en1, rsp_phase1_enable, bad);
               check_field("phase2_enable", want.en2, rsp_phase2_enable, bad);
               check_field("phase3_enable", want.en3, rsp_phase3_enable, bad);
               check_field("velocity", want.velocity, rsp_velocity, bad);
               check_field("active_command", want.active_command, rsp_active_command, bad);
               if (bad) mismatch_count++;
            end
         end
      end
      pending_beats <= predicted_drive_q.size();
   end

endmodule

// ===== bench/bldc_hall_commutation_speed_unit_tb.sv =====
`timescale 1ns / 1ps

module bldc_hall_commutation_speed_unit_tb;
   import bhcs_pkg::*;

   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_COMMAND = 1'b1;

   localparam logic [2:0] HALL_NONE = 3'b000;
   localparam logic [2:0] HALL_C    = 3'b001;
   localparam logic [2:0] HALL_B    = 3'b010;
   localparam logic [2:0] HALL_BC   = 3'b011;
   localparam logic [2:0] HALL_A    = 3'b100;
   localparam logic [2:0] HALL_AC   = 3'b101;
   localparam logic [2:0] HALL_AB   = 3'b110;
   localparam logic [2:0] HALL_ALL  = 3'b111;

   localparam int LIMIT_CYCLES    = 1000000;
   localparam int PHASES          = 8;
   localparam int BEATS_PER_PHASE = 200;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_kind;
   logic [2:0]            req_hall_code;
   logic signed [15:0]    req_command_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [14:0]           rsp_phase1_duty;
   logic [14:0]           rsp_phase2_duty;
   logic [14:0]           rsp_phase3_duty;
   logic                  rsp_phase1_enable;
   logic                  rsp_phase2_enable;
   logic                  rsp_phase3_enable;
   logic signed [15:0]    rsp_velocity;
   logic signed [15:0]    rsp_active_command;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int mismatch_count;
   int pending_beats;
   int send_idle_pct;
   int stall_pct;
   bit hold_off_go;
   int cycle_count;

   // Forward rotation order of the six valid hall codes.
   logic [2:0] rotation [6];
   int         rot_pos;
   int         dwell_left;
   bit         spin_fwd;
   int         cfg_cmd_bound;

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bldc_hall_commutation_speed_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_hall_code      (req_hall_code),
      .req_command_value  (req_command_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_phase1_duty    (rsp_phase1_duty),
      .rsp_phase2_duty    (rsp_phase2_duty),
      .rsp_phase3_duty    (rsp_phase3_duty),
      .rsp_phase1_enable  (rsp_phase1_enable),
      .rsp_phase2_enable  (rsp_phase2_enable),
      .rsp_phase3_enable  (rsp_phase3_enable),
      .rsp_velocity       (rsp_velocity),
      .rsp_active_command (rsp_active_command),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   bhcs_drive_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_hall_code      (req_hall_code),
      .req_command_value  (req_command_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_phase1_duty    (rsp_phase1_duty),
      .rsp_phase2_duty    (rsp_phase2_duty),
      .rsp_phase3_duty    (rsp_phase3_duty),
      .rsp_phase1_enable  (rsp_phase1_enable),
      .rsp_phase2_enable  (rsp_phase2_enable),
      .rsp_phase3_enable  (rsp_phase3_enable),
      .rsp_velocity       (rsp_velocity),
      .rsp_active_command (rsp_active_command),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatch_count     (mismatch_count),
      .pending_beats      (pending_beats)
   );

   // Receiver: random stalls, or one long hold-off when asked for.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("bldc_hall_commutation_speed_unit verification failed");
      $finish;
   end

   task automatic send_beat(input logic kind, input logic [2:0] hall,
                            input logic signed [15:0] cmd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_hall_code     <= hall;
      req_command_value <= cmd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Called in the step in which the last beat was taken.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_beats == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [23:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [23:0] speed_k, input logic [14:0] outlier,
                             input logic [23:0] emf_lim, input logic [7:0] gain,
                             input logic [14:0] cmd_lim);
      write_reg(CSR_SPEED_CONSTANT, speed_k);
      write_reg(CSR_DISCARD_THRESHOLD, {9'd0, outlier});
      write_reg(CSR_VOLTAGE_LIMIT, emf_lim);
      write_reg(CSR_BATTERY_GAIN, {16'd0, gain});
      write_reg(CSR_COMMAND_LIMIT, {9'd0, cmd_lim});
      csr_write <= 1'b0;
      @(posedge clock);
      cfg_cmd_bound = cmd_lim;
   endtask

   // Mostly clean rotation with random dwell, some commands near the limit,
   // and a little noise: stray hall codes and full-range commands.
   task automatic random_beat();
      int  r;
      int  mag;
      int  val;
      bit  step_fwd;
      r = $urandom_range(99);
      if (r < 75) begin
         if (dwell_left == 0) begin
            if ($urandom_range(49) == 0) spin_fwd = !spin_fwd;
            step_fwd   = ($urandom_range(9) == 0) ? !spin_fwd : spin_fwd;
            rot_pos    = step_fwd ? (rot_pos + 1) % 6 : (rot_pos + 5) % 6;
            dwell_left = ($urandom_range(19) == 0) ? $urandom_range(40, 1)
                                                   : $urandom_range(6, 1);
         end
         dwell_left--;
         send_beat(KIND_TICK, rotation[rot_pos], $urandom);
      end else if (r < 90) begin
         mag = $urandom_range(cfg_cmd_bound + cfg_cmd_bound / 8 + 1);
         val = $urandom_range(1) ? -mag : mag;
         if (val > 32767) val = 32767;
         if (val < -32768) val = -32768;
         send_beat(KIND_COMMAND, $urandom, val[15:0]);
      end else if (r < 95) begin
         send_beat(KIND_TICK, $urandom_range(7), $urandom);
      end else begin
         send_beat(KIND_COMMAND, $urandom, $urandom);
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_kind          = KIND_TICK;
      req_hall_code     = HALL_NONE;
      req_command_value = '0;
      csr_write         = 1'b0;
      csr_index         = CSR_SPEED_CONSTANT;
      csr_data          = '0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      hold_off_go       = 1'b0;
      rotation          = '{HALL_AB, HALL_B, HALL_BC, HALL_C, HALL_AC, HALL_A};
      rot_pos           = 0;
      dwell_left        = 0;
      spin_fwd          = 1'b1;
      cfg_cmd_bound     = RST_COMMAND_LIMIT;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Invalid codes at start-up, then a forward run that saturates the vote.
      send_beat(KIND_TICK, HALL_NONE, 16'sd0);
      send_beat(KIND_TICK, HALL_ALL, 16'sd0);
      send_beat(KIND_COMMAND, HALL_NONE, 16'sd500);
      send_beat(KIND_TICK, HALL_AB, 16'sd0);
      send_beat(KIND_TICK, HALL_AB, 16'sd0);
      send_beat(KIND_TICK, HALL_B, 16'sd0);
      send_beat(KIND_TICK, HALL_BC, 16'sd0);
      send_beat(KIND_TICK, HALL_C, 16'sd0);
      send_beat(KIND_TICK, HALL_AC, 16'sd0);
      send_beat(KIND_TICK, HALL_A, 16'sd0);
      // Just outside the command range, an over-voltage reject, then reverse drive.
      send_beat(KIND_COMMAND, HALL_ALL, 16'sd1001);
      send_beat(KIND_COMMAND, HALL_ALL, -16'sd1001);
      send_beat(KIND_COMMAND, HALL_ALL, -16'sd1000);
      send_beat(KIND_COMMAND, HALL_ALL, -16'sd900);
      send_beat(KIND_TICK, HALL_AB, 16'sd0);
      send_beat(KIND_TICK, HALL_ALL, 16'sd0);
      // Backward run from an invalid previous code until the vote flips.
      send_beat(KIND_TICK, HALL_A, 16'sd0);
      send_beat(KIND_TICK, HALL_AC, 16'sd0);
      send_beat(KIND_TICK, HALL_C, 16'sd0);
      send_beat(KIND_TICK, HALL_BC, 16'sd0);
      send_beat(KIND_TICK, HALL_B, 16'sd0);
      send_beat(KIND_TICK, HALL_AB, 16'sd0);
      send_beat(KIND_TICK, HALL_A, 16'sd0);
      send_beat(KIND_COMMAND, HALL_NONE, 16'sd32767);
      send_beat(KIND_COMMAND, HALL_NONE, -16'sd32768);
      send_beat(KIND_COMMAND, HALL_NONE, 16'sd0);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1: set_config(24'd60000, 15'd32767, 24'd58080, 8'd63, 15'd1000);
            2: set_config(24'hFFFFFF, 15'h7FFF, 24'hFFFFFF, 8'hFF, 15'h7FFF);
            3: set_config(24'd0, 15'd0, 24'd0, 8'd0, 15'd0);
            4: set_config(24'd20000, 15'd1500, 24'd200000, 8'd20, 15'd5000);
            5, 6: set_config($urandom_range(24'hFFFFFF), $urandom_range(15'h7FFF),
                             $urandom_range(24'hFFFFFF), $urandom_range(8'hFF),
                             $urandom_range(15'h7FFF));
            7: set_config(RST_SPEED_CONSTANT, RST_DISCARD_THRESHOLD, RST_VOLTAGE_LIMIT,
                          RST_BATTERY_GAIN, RST_COMMAND_LIMIT);
            default: ;
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 53; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 53; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         // The receiver holds off while beats keep coming, so the block backs up.
         if (phase == 4) hold_off_go = 1'b1;
         for (int n = 0; n < BEATS_PER_PHASE; n++) random_beat();
         drain();
      end

      if (mismatch_count == 0 && pending_beats == 0) begin
         $display("bldc_hall_commutation_speed_unit verification clean");
      end else begin
         $display("bldc_hall_commutation_speed_unit verification failed");
      end
      $finish;
   end

endmodule
